// ----- sv/twls_pkg.sv -----
// ----------------------------------------------------------------------------
// twls_pkg
// Shared types and constants of the time-weighted level statistics block.
// ----------------------------------------------------------------------------
package twls_pkg;

    localparam int FRAC_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int LEVEL_W   = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_LOW  = 2'd2;

    localparam logic [FRAC_W-1:0] FRACTION_HIGH_RESET = 17'd62259;
    localparam logic [FRAC_W-1:0] FRACTION_MID_RESET  = 17'd32768;
    localparam logic [FRAC_W-1:0] FRACTION_LOW_RESET  = 17'd3277;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TIME  = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    // round(10*log10(2) * 2^24)
    localparam logic [25:0] DB_PER_LOG2_Q24 = 26'd50504453;
    localparam logic [LEVEL_W-1:0] LEVEL_SILENT = 16'h8000;

    typedef struct packed {
        logic [31:0] sample_time;
        logic [31:0] sample_energy;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        duration;
        logic signed [15:0] equivalent_level;
        logic signed [15:0] level_at_high_fraction;
        logic signed [15:0] level_at_mid_fraction;
        logic signed [15:0] level_at_low_fraction;
    } t_out_word;

endpackage

// ----- sv/twls_div.sv -----
// ----------------------------------------------------------------------------
// twls_div
// Restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module twls_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [32:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [32:0] r_div;
    logic [33:0] rem_sh;
    logic        ge;
    logic [33:0] rem_sub;

    assign rem_sh  = {r_rem, r_quo[63]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[32:0] : rem_sh[32:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sv/twls_log.sv -----
// ----------------------------------------------------------------------------
// twls_log
// Level of a Q16.16 energy code in Q8.8 dB: leading-one search one bit per
// cycle, sixteen squaring steps for the log2 fraction, then one scaling
// multiply.
// ----------------------------------------------------------------------------
module twls_log
    import twls_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_x,
    output logic               o_done,
    output logic [LEVEL_W-1:0] o_code
);

    localparam logic [2:0] L_IDLE  = 3'd0;
    localparam logic [2:0] L_NORM  = 3'd1;
    localparam logic [2:0] L_SQ    = 3'd2;
    localparam logic [2:0] L_SCALE = 3'd3;
    localparam logic [2:0] L_FIN   = 3'd4;

    logic [2:0]         r_state;
    logic               r_done;
    logic [31:0]        r_m;
    logic [4:0]         r_k;
    logic [3:0]         r_i;
    logic [15:0]        r_frac;
    logic signed [48:0] r_p;
    logic [LEVEL_W-1:0] r_code;
    logic [63:0]        sq;
    logic [5:0]         k_off;
    logic signed [21:0] lg;
    logic signed [26:0] scale;
    logic signed [48:0] prod;
    logic signed [48:0] rounded;

    assign sq      = 64'(r_m) * 64'(r_m);
    assign k_off   = {1'b0, r_k} - 6'd16;
    assign lg      = {k_off, r_frac};
    assign scale   = {1'b0, DB_PER_LOG2_Q24};
    assign prod    = lg * scale;
    assign rounded = r_p + 49'sd2147483648;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        if (i_x == 32'd0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_m[31]) begin
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    if (r_i == 4'd15) begin
                        r_state <= L_SCALE;
                    end
                end
                L_SCALE: begin
                    r_state <= L_FIN;
                end
                L_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_m    <= i_x;
                r_k    <= 5'd31;
                r_i    <= '0;
                r_frac <= '0;
                if (i_start) begin
                    r_code <= LEVEL_SILENT;
                end
            end
            L_NORM: begin
                if (!r_m[31]) begin
                    r_m <= {r_m[30:0], 1'b0};
                    r_k <= r_k - 5'd1;
                end
            end
            L_SQ: begin
                r_i <= r_i + 4'd1;
                if (sq[63]) begin
                    r_m    <= sq[63:32];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_m    <= sq[62:31];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
            end
            L_SCALE: begin
                r_p <= prod;
            end
            L_FIN: begin
                r_code <= rounded[47:32];
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_code = r_code;

endmodule

// ----- sv/time_weighted_level_statistics_top.sv -----
// ----------------------------------------------------------------------------
// time_weighted_level_statistics_top
// Equivalent level and three time-fraction levels over one run of samples.
// ----------------------------------------------------------------------------
// Each input word is one (time, energy) sample; the word with last set closes
// the run and produces one result word. A sample is loaded, multiplied into
// the trapezoid sum if it follows an earlier sample in time order and no
// error is set, stored, and then checked for the close: the two trapezoid
// products share one 32x32 multiplier. Closing a run costs a division and a
// log for the equivalent level, then for each of the three fractions up to
// BISECTION_STEPS passes over the stored samples at one sample per cycle
// where the trial level cuts no segment, plus a multiply and the shared
// divider for every segment that it cuts through, plus a log. The sample
// memory port gives one read per cycle. The block stalls its input while a
// word is being worked on; a finished result waits in the output register
// while a new run loads. Samples past MAX_SAMPLES are dropped, but their last
// flag still closes the run. Fraction registers are to be written through
// the plain write port only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module time_weighted_level_statistics_top
    import twls_pkg::*;
#(
    parameter int MAX_SAMPLES     = 1024,
    parameter int BISECTION_STEPS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAC_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = $clog2(BISECTION_STEPS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LD    = 5'd1;
    localparam logic [4:0] S_LD2   = 5'd2;
    localparam logic [4:0] S_LD3   = 5'd3;
    localparam logic [4:0] S_STORE = 5'd4;
    localparam logic [4:0] S_CLOSE = 5'd5;
    localparam logic [4:0] S_MDIV  = 5'd6;
    localparam logic [4:0] S_MLOG  = 5'd7;
    localparam logic [4:0] S_FINIT = 5'd8;
    localparam logic [4:0] S_FTGT  = 5'd9;
    localparam logic [4:0] S_BTEST = 5'd10;
    localparam logic [4:0] S_W0    = 5'd11;
    localparam logic [4:0] S_WSEG  = 5'd12;
    localparam logic [4:0] S_WMUL  = 5'd13;
    localparam logic [4:0] S_WDIV  = 5'd14;
    localparam logic [4:0] S_BCMP  = 5'd15;
    localparam logic [4:0] S_FLOG  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    // Sample store.
    logic [31:0] mem_t [MAX_SAMPLES];
    logic [31:0] mem_e [MAX_SAMPLES];

    // Control state.
    logic [4:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [63:0]       r_integ;
    logic [31:0]       r_min;
    logic [31:0]       r_max;
    logic [1:0]        r_err;
    logic              r_out_valid;
    logic [FRAC_W-1:0] r_frac_high;
    logic [FRAC_W-1:0] r_frac_mid;
    logic [FRAC_W-1:0] r_frac_low;
    logic [1:0]        r_fsel;
    logic [SW-1:0]     r_step;
    logic [AW-1:0]     r_rd_addr;

    // Datapath registers.
    logic [31:0]  r_t;
    logic [31:0]  r_e;
    logic         r_last;
    logic [31:0]  r_prev_t;
    logic [31:0]  r_prev_e;
    logic [31:0]  r_first_t;
    logic [63:0]  r_p1;
    logic [63:0]  r_prod;
    logic [31:0]  r_dur;
    logic [1:0]   r_status;
    logic [15:0]  r_eq;
    logic [15:0]  r_lvl_high;
    logic [15:0]  r_lvl_mid;
    logic [15:0]  r_lvl_low;
    logic [31:0]  r_lo;
    logic [31:0]  r_hi;
    logic [31:0]  r_q;
    logic [31:0]  r_sum;
    logic [48:0]  r_target;
    logic [31:0]  r_seg_t;
    logic [31:0]  r_seg_e;
    logic [31:0]  r_ba;
    logic [31:0]  r_rd_t;
    logic [31:0]  r_rd_e;
    t_out_word    r_out_word;

    // Combinational helpers.
    logic          in_accept;
    logic          out_take;
    logic [31:0]   dt_in;
    logic [64:0]   add_s;
    logic [64:0]   add_n;
    logic [31:0]   seg_dt;
    logic [31:0]   seg_a;
    logic [31:0]   seg_b;
    logic [32:0]   mid_sum;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [FRAC_W-1:0] frac_sel;
    logic          last_seg;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] n_rd_addr;
    logic [31:0]   dur_now;
    logic          div_start;
    logic [63:0]   div_dividend;
    logic [32:0]   div_divisor;
    logic          div_done;
    logic [63:0]   div_quo;
    logic          log_start;
    logic [31:0]   log_x;
    logic          log_done;
    logic [15:0]   log_code;
    logic [1:0]    close_status;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign dt_in     = r_t - r_prev_t;
    assign add_s     = {1'b0, r_p1} + {1'b0, r_prod};
    assign add_n     = {1'b0, r_integ} + {1'b0, add_s[63:0]};
    assign seg_dt    = r_rd_t - r_seg_t;
    assign seg_a     = (r_seg_e > r_rd_e) ? r_rd_e : r_seg_e;
    assign seg_b     = (r_seg_e > r_rd_e) ? r_seg_e : r_rd_e;
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign count_m1  = r_count - CW'(1);
    assign last_seg  = (CW'(r_rd_addr) == count_m1);
    assign dur_now   = r_prev_t - r_first_t;
    assign close_status = (r_count < CW'(2)) ? ST_SHORT : r_err;

    always_comb begin
        case (r_fsel)
            2'd0:    frac_sel = r_frac_high;
            2'd1:    frac_sel = r_frac_mid;
            default: frac_sel = r_frac_low;
        endcase
    end

    // Shared multiplier operand selection; the product is registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_LD: begin
                mul_a = dt_in;
                mul_b = r_prev_e;
            end
            S_LD2: begin
                mul_a = dt_in;
                mul_b = r_e;
            end
            S_FINIT: begin
                mul_a = r_dur;
                mul_b = 32'(frac_sel);
            end
            S_WSEG: begin
                mul_a = seg_dt;
                mul_b = r_q - seg_a;
            end
            default: begin
            end
        endcase
    end

    // Divider and log start requests.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_integ;
        div_divisor  = {dur_now, 1'b0};
        log_start    = 1'b0;
        log_x        = div_quo[31:0];
        if ((r_state == S_CLOSE) && r_last && (close_status == ST_OK)) begin
            div_start = 1'b1;
        end
        if (r_state == S_WMUL) begin
            div_start    = 1'b1;
            div_dividend = r_prod;
            div_divisor  = {1'b0, r_ba};
        end
        if ((r_state == S_MDIV) && div_done) begin
            log_start = 1'b1;
        end
        if ((r_state == S_BTEST) &&
            !((r_step < SW'(BISECTION_STEPS)) && (r_lo < r_hi))) begin
            log_start = 1'b1;
            log_x     = mid_sum[32:1];
        end
    end

    // Next read address of the sample store.
    always_comb begin
        n_rd_addr = r_rd_addr;
        case (r_state)
            S_BTEST: n_rd_addr = '0;
            S_W0:    n_rd_addr = AW'(1);
            S_WSEG: begin
                if (((r_q >= seg_b) || (r_q <= seg_a)) && !last_seg) begin
                    n_rd_addr = r_rd_addr + AW'(1);
                end
            end
            S_WDIV: begin
                if (div_done && !last_seg) begin
                    n_rd_addr = r_rd_addr + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_STORE) && (r_count < CW'(MAX_SAMPLES))) begin
            mem_t[r_count[AW-1:0]] <= r_t;
            mem_e[r_count[AW-1:0]] <= r_e;
        end
        r_rd_t <= mem_t[n_rd_addr];
        r_rd_e <= mem_e[n_rd_addr];
    end

    twls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    twls_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_code  (log_code)
    );

    // Sequencer and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_integ     <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
            r_frac_high <= FRACTION_HIGH_RESET;
            r_frac_mid  <= FRACTION_MID_RESET;
            r_frac_low  <= FRACTION_LOW_RESET;
            r_fsel      <= '0;
            r_step      <= '0;
            r_rd_addr   <= '0;
        end else begin
            r_rd_addr <= n_rd_addr;
            // In S_OUT the valid flag is handled by the output step below.
            if (out_take && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FRACTION_HIGH: r_frac_high <= i_cfg_data;
                    REG_FRACTION_MID:  r_frac_mid  <= i_cfg_data;
                    REG_FRACTION_LOW:  r_frac_low  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_LD;
                    end
                end
                S_LD: begin
                    if (r_count >= CW'(MAX_SAMPLES)) begin
                        r_state <= S_CLOSE;
                    end else if ((r_count != '0) && (r_err != ST_TIME)) begin
                        if (r_t <= r_prev_t) begin
                            r_err   <= ST_TIME;
                            r_state <= S_STORE;
                        end else if (r_err == ST_OK) begin
                            r_state <= S_LD2;
                        end else begin
                            r_state <= S_STORE;
                        end
                    end else begin
                        r_state <= S_STORE;
                    end
                end
                S_LD2: begin
                    r_state <= S_LD3;
                end
                S_LD3: begin
                    if (add_s[64] || add_n[64]) begin
                        r_err <= ST_OVF;
                    end else begin
                        r_integ <= add_n[63:0];
                    end
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    r_count <= r_count + CW'(1);
                    if (r_e < r_min) begin
                        r_min <= r_e;
                    end
                    if (r_e > r_max) begin
                        r_max <= r_e;
                    end
                    r_state <= S_CLOSE;
                end
                S_CLOSE: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (close_status != ST_OK) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (div_done) begin
                        r_state <= S_MLOG;
                    end
                end
                S_MLOG: begin
                    if (log_done) begin
                        r_fsel  <= '0;
                        r_state <= S_FINIT;
                    end
                end
                S_FINIT: begin
                    r_step  <= '0;
                    r_state <= S_FTGT;
                end
                S_FTGT: begin
                    r_state <= S_BTEST;
                end
                S_BTEST: begin
                    if ((r_step < SW'(BISECTION_STEPS)) && (r_lo < r_hi)) begin
                        r_state <= S_W0;
                    end else begin
                        r_state <= S_FLOG;
                    end
                end
                S_W0: begin
                    r_state <= S_WSEG;
                end
                S_WSEG: begin
                    if ((r_q < seg_b) && (r_q > seg_a)) begin
                        r_state <= S_WMUL;
                    end else if (last_seg) begin
                        r_state <= S_BCMP;
                    end
                end
                S_WMUL: begin
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    if (div_done) begin
                        r_state <= last_seg ? S_BCMP : S_WSEG;
                    end
                end
                S_BCMP: begin
                    r_step  <= r_step + SW'(1);
                    r_state <= S_BTEST;
                end
                S_FLOG: begin
                    if (log_done) begin
                        if (r_fsel == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_fsel  <= r_fsel + 2'd1;
                            r_state <= S_FINIT;
                        end
                    end
                end
                S_OUT: begin
                    // The result waits here only if the previous one has
                    // not been taken yet.
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                        r_integ     <= '0;
                        r_min       <= '1;
                        r_max       <= '0;
                        r_err       <= ST_OK;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_t    <= i_in_word.sample_time;
                    r_e    <= i_in_word.sample_energy;
                    r_last <= i_in_word.last;
                end
            end
            S_LD2: begin
                r_p1 <= r_prod;
            end
            S_STORE: begin
                r_prev_t <= r_t;
                r_prev_e <= r_e;
                if (r_count == '0) begin
                    r_first_t <= r_t;
                end
            end
            S_CLOSE: begin
                r_status   <= close_status;
                r_dur      <= (close_status == ST_OK) ? dur_now : 32'd0;
                r_eq       <= '0;
                r_lvl_high <= '0;
                r_lvl_mid  <= '0;
                r_lvl_low  <= '0;
            end
            S_MLOG: begin
                if (log_done) begin
                    r_eq <= log_code;
                end
            end
            S_FINIT: begin
                r_lo <= r_min;
                r_hi <= r_max;
            end
            S_FTGT: begin
                r_target <= r_prod[48:0];
            end
            S_BTEST: begin
                r_q   <= mid_sum[32:1];
                r_sum <= '0;
            end
            S_W0: begin
                r_seg_t <= r_rd_t;
                r_seg_e <= r_rd_e;
            end
            S_WSEG: begin
                r_seg_t <= r_rd_t;
                r_seg_e <= r_rd_e;
                r_ba    <= seg_b - seg_a;
                if (r_q >= seg_b) begin
                    r_sum <= r_sum + seg_dt;
                end
            end
            S_WDIV: begin
                if (div_done) begin
                    r_sum <= r_sum + div_quo[31:0];
                end
            end
            S_BCMP: begin
                if ({1'b0, r_sum, 16'b0} < r_target) begin
                    r_lo <= r_q;
                end else begin
                    r_hi <= r_q;
                end
            end
            S_FLOG: begin
                if (log_done) begin
                    case (r_fsel)
                        2'd0:    r_lvl_high <= log_code;
                        2'd1:    r_lvl_mid  <= log_code;
                        default: r_lvl_low  <= log_code;
                    endcase
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out_word.status                 <= r_status;
                    r_out_word.duration               <= r_dur;
                    r_out_word.equivalent_level       <= r_eq;
                    r_out_word.level_at_high_fraction <= r_lvl_high;
                    r_out_word.level_at_mid_fraction  <= r_lvl_mid;
                    r_out_word.level_at_low_fraction  <= r_lvl_low;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
